/* hdl/aarm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pkg: shared constants and types for the rotation vector unit
// Fixed-point formats, stage counts and the arctangent table used by the
// square root, divider, cordic and matrix stages.
// ----------------------------------------------------------------------------
package aarm_pkg;

   // pipeline configuration
   localparam int CORDIC_STAGES = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int Q             = 30;
   localparam int ATAN_COUNT    = 24;

   // field widths
   localparam int IN_W  = 16;
   localparam int OUT_W = 16;

   // internal widths
   localparam int SUM_W      = 32;
   localparam int ROOT_W     = 32;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int QUO_W      = 31;
   localparam int DIV_STEPS  = QUO_W;
   localparam int MAG_SHIFT  = 15;
   localparam int U_W        = 32;
   localparam int CW         = 34;
   localparam int ZW         = 36;
   localparam int TW         = 35;
   localparam int PW         = 34;
   localparam int MW         = 36;

   // total latency from accepted beat to result strobe
   localparam int LATENCY = 1 + SQRT_STEPS + DIV_STEPS + CORDIC_STAGES + 2 + 3;

   // angle constants, 30 fraction bits
   localparam logic signed [ZW-1:0] PI_Q      = 36'sd3373259426;
   localparam logic signed [ZW-1:0] TWO_PI_Q  = 36'sd6746518852;
   localparam logic signed [ZW-1:0] HALF_PI_Q = 36'sd1686629713;
   localparam logic signed [CW-1:0] GAIN_Q    = 34'sh026DD3B6A;
   localparam logic signed [TW-1:0] ONE_Q     = 35'sh040000000;

   // arctan(2^-i), truncated to 30 fraction bits
   localparam logic [31:0] ATAN_Q [ATAN_COUNT] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   // control travelling with each beat
   typedef struct packed {
      logic valid;
      logic ident;
   } ctl_type;

endpackage

/* hdl/aarm_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_sqrt: pipelined integer square root
// One result bit per stage; computes floor(sqrt(sum * 2^32)) and carries
// the rotation vector alongside.
// ----------------------------------------------------------------------------
module aarm_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  aarm_pkg::ctl_type                   in_ctl,
   input  logic [aarm_pkg::SUM_W-1:0]          in_sum,
   input  logic signed [aarm_pkg::IN_W-1:0]    in_rot [3],
   output aarm_pkg::ctl_type                   out_ctl,
   output logic [aarm_pkg::ROOT_W-1:0]         out_root,
   output logic signed [aarm_pkg::IN_W-1:0]    out_rot [3]
);

   aarm_pkg::ctl_type                 ctl_ff  [aarm_pkg::SQRT_STEPS];
   logic [aarm_pkg::SUM_W-1:0]        sum_ff  [aarm_pkg::SQRT_STEPS];
   logic [aarm_pkg::ROOT_W-1:0]       root_ff [aarm_pkg::SQRT_STEPS];
   logic [aarm_pkg::REM_W-1:0]        rem_ff  [aarm_pkg::SQRT_STEPS];
   logic signed [aarm_pkg::IN_W-1:0]  rot_ff  [aarm_pkg::SQRT_STEPS][3];

   for (genvar g = 0; g < aarm_pkg::SQRT_STEPS; g++) begin : g_step
      aarm_pkg::ctl_type                ctl_prev;
      logic [aarm_pkg::SUM_W-1:0]       sum_prev;
      logic [aarm_pkg::ROOT_W-1:0]      root_prev;
      logic [aarm_pkg::REM_W-1:0]       rem_prev;
      logic [aarm_pkg::REM_W-1:0]       rem_sh;
      logic [aarm_pkg::REM_W-1:0]       trial;
      logic signed [aarm_pkg::IN_W-1:0] rot_prev [3];

      // previous stage or pipeline input
      if (g == 0) begin : g_first
         assign ctl_prev  = in_ctl;
         assign sum_prev  = in_sum;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign rot_prev  = in_rot;
      end else begin : g_next
         assign ctl_prev  = ctl_ff[g-1];
         assign sum_prev  = sum_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign rot_prev  = rot_ff[g-1];
      end

      // bring down the next digit pair and try the next root bit
      assign rem_sh = {rem_prev[aarm_pkg::REM_W-3:0], sum_prev[aarm_pkg::SUM_W-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g] <= '0;
         end else begin
            ctl_ff[g] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         sum_ff[g] <= {sum_prev[aarm_pkg::SUM_W-3:0], 2'b00};
         rot_ff[g] <= rot_prev;
         if (rem_sh >= trial) begin
            rem_ff[g]  <= rem_sh - trial;
            root_ff[g] <= {root_prev[aarm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[g]  <= rem_sh;
            root_ff[g] <= {root_prev[aarm_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign out_ctl  = ctl_ff[aarm_pkg::SQRT_STEPS-1];
   assign out_root = root_ff[aarm_pkg::SQRT_STEPS-1];
   assign out_rot  = rot_ff[aarm_pkg::SQRT_STEPS-1];

endmodule

/* hdl/aarm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_div: three-lane pipelined restoring divider
// Each lane forms |r| * 2^46 / angle, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aarm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  aarm_pkg::ctl_type                   in_ctl,
   input  logic [aarm_pkg::ROOT_W-1:0]         in_root,
   input  logic signed [aarm_pkg::IN_W-1:0]    in_rot [3],
   output aarm_pkg::ctl_type                   out_ctl,
   output logic [aarm_pkg::ROOT_W-1:0]         out_root,
   output logic [aarm_pkg::QUO_W-1:0]          out_quo [3],
   output logic                                out_neg [3]
);

   aarm_pkg::ctl_type            ctl_ff  [aarm_pkg::DIV_STEPS];
   logic [aarm_pkg::ROOT_W-1:0]  root_ff [aarm_pkg::DIV_STEPS];
   logic [aarm_pkg::ROOT_W-1:0]  rem_ff  [aarm_pkg::DIV_STEPS][3];
   logic [aarm_pkg::QUO_W-1:0]   quo_ff  [aarm_pkg::DIV_STEPS][3];
   logic                         neg_ff  [aarm_pkg::DIV_STEPS][3];

   // lane start values: magnitude aligned so the quotient fits QUO_W bits
   logic [aarm_pkg::ROOT_W-1:0]  rem_init [3];
   logic                         neg_init [3];
   logic [aarm_pkg::IN_W-1:0]    mag      [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg_init[k] = in_rot[k][aarm_pkg::IN_W-1];
         mag[k]      = neg_init[k] ? aarm_pkg::IN_W'(-in_rot[k]) : aarm_pkg::IN_W'(in_rot[k]);
         rem_init[k] = aarm_pkg::ROOT_W'({mag[k], {aarm_pkg::MAG_SHIFT{1'b0}}});
      end
   end

   for (genvar g = 0; g < aarm_pkg::DIV_STEPS; g++) begin : g_step
      aarm_pkg::ctl_type            ctl_prev;
      logic [aarm_pkg::ROOT_W-1:0]  root_prev;
      logic [aarm_pkg::ROOT_W-1:0]  rem_prev [3];
      logic [aarm_pkg::QUO_W-1:0]   quo_prev [3];
      logic                         neg_prev [3];

      if (g == 0) begin : g_first
         assign ctl_prev  = in_ctl;
         assign root_prev = in_root;
         assign rem_prev  = rem_init;
         assign neg_prev  = neg_init;
         assign quo_prev  = '{default: '0};
      end else begin : g_next
         assign ctl_prev  = ctl_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign neg_prev  = neg_ff[g-1];
         assign quo_prev  = quo_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g] <= '0;
         end else begin
            ctl_ff[g] <= ctl_prev;
         end
      end

      // one trial subtraction per lane
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [aarm_pkg::ROOT_W:0] rem_sh;
         logic [aarm_pkg::ROOT_W:0] dvs;

         assign rem_sh = {rem_prev[k], 1'b0};
         assign dvs    = {1'b0, root_prev};

         always_ff @(posedge clock) begin
            neg_ff[g][k] <= neg_prev[k];
            if (rem_sh >= dvs) begin
               rem_ff[g][k] <= aarm_pkg::ROOT_W'(rem_sh - dvs);
               quo_ff[g][k] <= {quo_prev[k][aarm_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[g][k] <= rem_sh[aarm_pkg::ROOT_W-1:0];
               quo_ff[g][k] <= {quo_prev[k][aarm_pkg::QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         root_ff[g] <= root_prev;
      end
   end

   assign out_ctl  = ctl_ff[aarm_pkg::DIV_STEPS-1];
   assign out_root = root_ff[aarm_pkg::DIV_STEPS-1];
   assign out_quo  = quo_ff[aarm_pkg::DIV_STEPS-1];
   assign out_neg  = neg_ff[aarm_pkg::DIV_STEPS-1];

endmodule

/* hdl/aarm_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_cordic: angle reduction and pipelined cordic
// Reduces the angle into [-pi/2, pi/2], runs one rotation per stage and
// restores the quadrant, giving cosine and sine with 30 fraction bits.
// ----------------------------------------------------------------------------
module aarm_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  aarm_pkg::ctl_type                   in_ctl,
   input  logic [aarm_pkg::ROOT_W-1:0]         in_root,
   input  logic [aarm_pkg::QUO_W-1:0]          in_quo [3],
   input  logic                                in_neg [3],
   output aarm_pkg::ctl_type                   out_ctl,
   output logic signed [aarm_pkg::CW-1:0]      out_cos,
   output logic signed [aarm_pkg::CW-1:0]      out_sin,
   output logic signed [aarm_pkg::U_W-1:0]     out_axis [3]
);

   localparam int NS = aarm_pkg::CORDIC_STAGES;

   aarm_pkg::ctl_type                  ctl_ff  [NS+1];
   logic                               flip_ff [NS+1];
   logic signed [aarm_pkg::U_W-1:0]    axis_ff [NS+1][3];
   logic signed [aarm_pkg::ZW-1:0]     z_ff    [NS];
   logic signed [aarm_pkg::CW-1:0]     x_ff    [NS];
   logic signed [aarm_pkg::CW-1:0]     y_ff    [NS];

   // reduction stage
   logic signed [aarm_pkg::ZW-1:0]     th;
   logic signed [aarm_pkg::ZW-1:0]     th_wrap;
   logic signed [aarm_pkg::ZW-1:0]     z_in;
   logic                               flip_in;
   logic signed [aarm_pkg::U_W-1:0]    axis_in [3];

   always_comb begin
      th      = signed'(aarm_pkg::ZW'({in_root, 1'b0}));
      th_wrap = (th > aarm_pkg::PI_Q) ? th - aarm_pkg::TWO_PI_Q : th;
      priority if (th_wrap > aarm_pkg::HALF_PI_Q) begin
         z_in    = th_wrap - aarm_pkg::PI_Q;
         flip_in = 1'b1;
      end else if (th_wrap < -aarm_pkg::HALF_PI_Q) begin
         z_in    = th_wrap + aarm_pkg::PI_Q;
         flip_in = 1'b1;
      end else begin
         z_in    = th_wrap;
         flip_in = 1'b0;
      end
      for (int k = 0; k < 3; k++) begin
         axis_in[k] = in_neg[k] ? -signed'({1'b0, in_quo[k]}) : signed'({1'b0, in_quo[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      z_ff[0]    <= z_in;
      flip_ff[0] <= flip_in;
      axis_ff[0] <= axis_in;
   end

   // rotation stages
   for (genvar g = 0; g < NS; g++) begin : g_rot
      logic signed [aarm_pkg::CW-1:0] x_prev;
      logic signed [aarm_pkg::CW-1:0] y_prev;
      logic signed [aarm_pkg::CW-1:0] dx;
      logic signed [aarm_pkg::CW-1:0] dy;
      logic signed [aarm_pkg::ZW-1:0] at;
      logic signed [aarm_pkg::ZW-1:0] z_next;

      if (g == 0) begin : g_first
         assign x_prev = aarm_pkg::GAIN_Q;
         assign y_prev = '0;
      end else begin : g_next
         assign x_prev = x_ff[g-1];
         assign y_prev = y_ff[g-1];
      end

      assign dx = y_prev >>> g;
      assign dy = x_prev >>> g;
      assign at = signed'(aarm_pkg::ZW'(aarm_pkg::ATAN_Q[g]));
      assign z_next = z_ff[g][aarm_pkg::ZW-1] ? z_ff[g] + at : z_ff[g] - at;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g+1] <= '0;
         end else begin
            ctl_ff[g+1] <= ctl_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         flip_ff[g+1] <= flip_ff[g];
         axis_ff[g+1] <= axis_ff[g];
         if (z_ff[g][aarm_pkg::ZW-1]) begin
            x_ff[g] <= x_prev + dx;
            y_ff[g] <= y_prev - dy;
         end else begin
            x_ff[g] <= x_prev - dx;
            y_ff[g] <= y_prev + dy;
         end
      end

      if (g < NS - 1) begin : g_zreg
         always_ff @(posedge clock) begin
            z_ff[g+1] <= z_next;
         end
      end
   end

   // quadrant restore
   aarm_pkg::ctl_type                ctl_out_ff;
   logic signed [aarm_pkg::CW-1:0]   cos_ff;
   logic signed [aarm_pkg::CW-1:0]   sin_ff;
   logic signed [aarm_pkg::U_W-1:0]  axis_out_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_out_ff <= '0;
      end else begin
         ctl_out_ff <= ctl_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      cos_ff      <= flip_ff[NS] ? -x_ff[NS-1] : x_ff[NS-1];
      sin_ff      <= flip_ff[NS] ? -y_ff[NS-1] : y_ff[NS-1];
      axis_out_ff <= axis_ff[NS];
   end

   assign out_ctl  = ctl_out_ff;
   assign out_cos  = cos_ff;
   assign out_sin  = sin_ff;
   assign out_axis = axis_out_ff;

endmodule

/* hdl/aarm_mat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_mat: Rodrigues matrix assembly
// Two multiply stages form the outer and cross products, a third sums,
// rounds, saturates and substitutes the identity for a zero vector.
// ----------------------------------------------------------------------------
module aarm_mat (
   input  logic                                clock,
   input  logic                                reset,
   input  aarm_pkg::ctl_type                   in_ctl,
   input  logic signed [aarm_pkg::CW-1:0]      in_cos,
   input  logic signed [aarm_pkg::CW-1:0]      in_sin,
   input  logic signed [aarm_pkg::U_W-1:0]     in_axis [3],
   output aarm_pkg::ctl_type                   out_ctl,
   output logic [aarm_pkg::OUT_W-1:0]          out_m [9]
);

   localparam int OUT_SHIFT = aarm_pkg::Q - aarm_pkg::OUT_FRAC_BITS;
   localparam logic signed [aarm_pkg::MW:0] OUT_RND = (aarm_pkg::MW+1)'(1) <<< (OUT_SHIFT - 1);
   localparam logic signed [aarm_pkg::MW:0] OUT_LIM =
      (aarm_pkg::MW+1)'(1) <<< aarm_pkg::OUT_FRAC_BITS;
   localparam logic [aarm_pkg::OUT_W-1:0] OUT_ONE = aarm_pkg::OUT_W'(OUT_LIM);

   // fixed-point product, floored back to 30 fraction bits
   function automatic logic signed [aarm_pkg::PW-1:0] mulq(
      input logic signed [aarm_pkg::TW-1:0]  a,
      input logic signed [aarm_pkg::U_W-1:0] b
   );
      logic signed [aarm_pkg::TW+aarm_pkg::U_W-1:0] p;
      p = a * b;
      return aarm_pkg::PW'(p >>> aarm_pkg::Q);
   endfunction

   // round half up, saturate to plus or minus one
   function automatic logic [aarm_pkg::OUT_W-1:0] to_out(
      input logic signed [aarm_pkg::MW-1:0] v
   );
      logic signed [aarm_pkg::MW:0] r;
      r = ((aarm_pkg::MW+1)'(v) + OUT_RND) >>> OUT_SHIFT;
      if (r > OUT_LIM) begin
         r = OUT_LIM;
      end else if (r < -OUT_LIM) begin
         r = -OUT_LIM;
      end
      return r[aarm_pkg::OUT_W-1:0];
   endfunction

   // stage 1: t*u and s*u
   aarm_pkg::ctl_type                 ctl1_ff;
   logic signed [aarm_pkg::PW-1:0]    tv1_ff [3];
   logic signed [aarm_pkg::PW-1:0]    sv1_ff [3];
   logic signed [aarm_pkg::CW-1:0]    c1_ff;
   logic signed [aarm_pkg::U_W-1:0]   u1_ff  [3];
   logic signed [aarm_pkg::TW-1:0]    t_in;

   assign t_in = aarm_pkg::ONE_Q - aarm_pkg::TW'(in_cos);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         tv1_ff[k] <= mulq(t_in, in_axis[k]);
         sv1_ff[k] <= mulq(aarm_pkg::TW'(in_sin), in_axis[k]);
      end
      c1_ff <= in_cos;
      u1_ff <= in_axis;
   end

   // stage 2: outer product terms
   aarm_pkg::ctl_type                 ctl2_ff;
   logic signed [aarm_pkg::PW-1:0]    txx_ff, txy_ff, txz_ff, tyy_ff, tyz_ff, tzz_ff;
   logic signed [aarm_pkg::PW-1:0]    sv2_ff [3];
   logic signed [aarm_pkg::CW-1:0]    c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      txx_ff <= mulq(aarm_pkg::TW'(tv1_ff[0]), u1_ff[0]);
      txy_ff <= mulq(aarm_pkg::TW'(tv1_ff[0]), u1_ff[1]);
      txz_ff <= mulq(aarm_pkg::TW'(tv1_ff[0]), u1_ff[2]);
      tyy_ff <= mulq(aarm_pkg::TW'(tv1_ff[1]), u1_ff[1]);
      tyz_ff <= mulq(aarm_pkg::TW'(tv1_ff[1]), u1_ff[2]);
      tzz_ff <= mulq(aarm_pkg::TW'(tv1_ff[2]), u1_ff[2]);
      sv2_ff <= sv1_ff;
      c2_ff  <= c1_ff;
   end

   // stage 3: sums, rounding, identity substitution
   logic signed [aarm_pkg::MW-1:0]    sum_in [9];
   logic [aarm_pkg::OUT_W-1:0]        m_in   [9];
   aarm_pkg::ctl_type                 ctl3_ff;
   logic [aarm_pkg::OUT_W-1:0]        m_ff   [9];

   always_comb begin
      sum_in[0] = aarm_pkg::MW'(txx_ff) + aarm_pkg::MW'(c2_ff);
      sum_in[1] = aarm_pkg::MW'(txy_ff) - aarm_pkg::MW'(sv2_ff[2]);
      sum_in[2] = aarm_pkg::MW'(txz_ff) + aarm_pkg::MW'(sv2_ff[1]);
      sum_in[3] = aarm_pkg::MW'(txy_ff) + aarm_pkg::MW'(sv2_ff[2]);
      sum_in[4] = aarm_pkg::MW'(tyy_ff) + aarm_pkg::MW'(c2_ff);
      sum_in[5] = aarm_pkg::MW'(tyz_ff) - aarm_pkg::MW'(sv2_ff[0]);
      sum_in[6] = aarm_pkg::MW'(txz_ff) - aarm_pkg::MW'(sv2_ff[1]);
      sum_in[7] = aarm_pkg::MW'(tyz_ff) + aarm_pkg::MW'(sv2_ff[0]);
      sum_in[8] = aarm_pkg::MW'(tzz_ff) + aarm_pkg::MW'(c2_ff);
      for (int k = 0; k < 9; k++) begin
         if (ctl2_ff.ident) begin
            m_in[k] = (k % 4 == 0) ? OUT_ONE : '0;
         end else begin
            m_in[k] = to_out(sum_in[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end

   assign out_ctl = ctl3_ff;
   assign out_m   = m_ff;

endmodule

/* hdl/axis_angle_to_rotation_matrix_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_unit: rotation vector to rotation matrix
//
// Input: req_rot_x/y/z, signed, 13 fraction bits, taken on any clock edge
// with start high; busy is always low, so a new beat may enter every cycle.
// Output: the nine Rodrigues matrix entries rsp_m00..rsp_m22 (signed, 14
// fraction bits, saturated to +-1.0) and rsp_was_identity, shown for one
// cycle with rsp_valid high. A zero vector gives the identity matrix.
// The pipeline has one input stage for the sum of squares, 32 square
// root stages (one root bit each), 31 divider stages (one quotient bit
// each, three lanes), one angle reduction stage, 16 cordic stages, one
// quadrant stage and three matrix stages. Throughput is one beat per cycle.
// Results leave in order; the receiver takes every strobe as it comes.
// Reset clears only the valid and identity bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [aarm_pkg::IN_W-1:0]   req_rot_x,
   input  logic signed [aarm_pkg::IN_W-1:0]   req_rot_y,
   input  logic signed [aarm_pkg::IN_W-1:0]   req_rot_z,
   output logic                               rsp_valid,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m00,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m01,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m02,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m10,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m11,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m12,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m20,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m21,
   output logic signed [aarm_pkg::OUT_W-1:0]  rsp_m22,
   output logic                               rsp_was_identity
);

   // fully pipelined, never holds off a beat
   assign busy = 1'b0;

   // input stage: sum of squares
   logic signed [2*aarm_pkg::IN_W-1:0] sq_x, sq_y, sq_z;
   logic [aarm_pkg::SUM_W-1:0]         sum_in;
   aarm_pkg::ctl_type                  ctl_in;
   aarm_pkg::ctl_type                  in_ctl_ff;
   logic [aarm_pkg::SUM_W-1:0]         sum_ff;
   logic signed [aarm_pkg::IN_W-1:0]   rot_ff [3];

   assign sq_x   = req_rot_x * req_rot_x;
   assign sq_y   = req_rot_y * req_rot_y;
   assign sq_z   = req_rot_z * req_rot_z;
   assign sum_in = aarm_pkg::SUM_W'($unsigned(sq_x)) + aarm_pkg::SUM_W'($unsigned(sq_y))
                 + aarm_pkg::SUM_W'($unsigned(sq_z));
   assign ctl_in = '{valid: start & ~busy, ident: (sum_in == '0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else begin
         in_ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      rot_ff[0] <= req_rot_x;
      rot_ff[1] <= req_rot_y;
      rot_ff[2] <= req_rot_z;
   end

   // angle
   aarm_pkg::ctl_type                  sq_ctl;
   logic [aarm_pkg::ROOT_W-1:0]        sq_root;
   logic signed [aarm_pkg::IN_W-1:0]   sq_rot [3];

   aarm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (in_ctl_ff),
      .in_sum   (sum_ff),
      .in_rot   (rot_ff),
      .out_ctl  (sq_ctl),
      .out_root (sq_root),
      .out_rot  (sq_rot)
   );

   // unit axis
   aarm_pkg::ctl_type                  dv_ctl;
   logic [aarm_pkg::ROOT_W-1:0]        dv_root;
   logic [aarm_pkg::QUO_W-1:0]         dv_quo [3];
   logic                               dv_neg [3];

   aarm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (sq_ctl),
      .in_root  (sq_root),
      .in_rot   (sq_rot),
      .out_ctl  (dv_ctl),
      .out_root (dv_root),
      .out_quo  (dv_quo),
      .out_neg  (dv_neg)
   );

   // sine and cosine
   aarm_pkg::ctl_type                  cr_ctl;
   logic signed [aarm_pkg::CW-1:0]     cr_cos;
   logic signed [aarm_pkg::CW-1:0]     cr_sin;
   logic signed [aarm_pkg::U_W-1:0]    cr_axis [3];

   aarm_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (dv_ctl),
      .in_root  (dv_root),
      .in_quo   (dv_quo),
      .in_neg   (dv_neg),
      .out_ctl  (cr_ctl),
      .out_cos  (cr_cos),
      .out_sin  (cr_sin),
      .out_axis (cr_axis)
   );

   // matrix
   aarm_pkg::ctl_type                  mt_ctl;
   logic [aarm_pkg::OUT_W-1:0]         mt_m [9];

   aarm_mat u_mat (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (cr_ctl),
      .in_cos   (cr_cos),
      .in_sin   (cr_sin),
      .in_axis  (cr_axis),
      .out_ctl  (mt_ctl),
      .out_m    (mt_m)
   );

   assign rsp_valid        = mt_ctl.valid;
   assign rsp_was_identity = mt_ctl.ident;
   assign rsp_m00          = mt_m[0];
   assign rsp_m01          = mt_m[1];
   assign rsp_m02          = mt_m[2];
   assign rsp_m10          = mt_m[3];
   assign rsp_m11          = mt_m[4];
   assign rsp_m12          = mt_m[5];
   assign rsp_m20          = mt_m[6];
   assign rsp_m21          = mt_m[7];
   assign rsp_m22          = mt_m[8];

   // every accepted beat leaves after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(aarm_pkg::LATENCY) rsp_valid)
      else $error("accepted beat did not produce a result on time");

   // identity results carry exact unit diagonal and zero elsewhere
   a_ident : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_identity) |->
         (rsp_m00 == 16'sd16384) && (rsp_m11 == 16'sd16384) && (rsp_m22 == 16'sd16384) &&
         (rsp_m01 == '0) && (rsp_m02 == '0) && (rsp_m10 == '0) &&
         (rsp_m12 == '0) && (rsp_m20 == '0) && (rsp_m21 == '0))
      else $error("identity result malformed");

   // saturation keeps the diagonal within plus or minus one
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_m00 <= 16'sd16384) && (rsp_m00 >= -16'sd16384) &&
         (rsp_m11 <= 16'sd16384) && (rsp_m11 >= -16'sd16384) &&
         (rsp_m22 <= 16'sd16384) && (rsp_m22 >= -16'sd16384))
      else $error("matrix entry out of range");

endmodule

/* sim/aarm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_checker: result predictor and scoreboard for the rotation vector unit
// Watches accepted request beats, computes the expected Rodrigues matrix
// for each one and compares every response strobe against the oldest one.
// ----------------------------------------------------------------------------
module aarm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic signed [aarm_pkg::IN_W-1:0]  req_rot_x,
   input  logic signed [aarm_pkg::IN_W-1:0]  req_rot_y,
   input  logic signed [aarm_pkg::IN_W-1:0]  req_rot_z,
   input  logic                              rsp_valid,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m00,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m01,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m02,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m10,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m11,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m12,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m20,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m21,
   input  logic signed [aarm_pkg::OUT_W-1:0] rsp_m22,
   input  logic                              rsp_was_identity,
   output int                                fail_count,
   output int                                pending,
   output int                                matrices_seen,
   output int                                identities_seen
);

   typedef struct {
      logic [aarm_pkg::OUT_W-1:0] m [9];
      logic                       ident;
   } rot_matrix_type;

   rot_matrix_type matrix_queue [$];

   // floor shift of a signed value
   function automatic longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return floor_shr(a * b, aarm_pkg::Q);
   endfunction

   function automatic logic [aarm_pkg::OUT_W-1:0] round_sat(longint v);
      longint r, lim;
      lim = longint'(1) << aarm_pkg::OUT_FRAC_BITS;
      r = floor_shr(v + (longint'(1) << (aarm_pkg::Q - aarm_pkg::OUT_FRAC_BITS - 1)),
                    aarm_pkg::Q - aarm_pkg::OUT_FRAC_BITS);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[aarm_pkg::OUT_W-1:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned rem, root, b;
      rem = v; root = 0; b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic rot_matrix_type rodrigues(logic signed [aarm_pkg::IN_W-1:0] vx,
                                                logic signed [aarm_pkg::IN_W-1:0] vy,
                                                logic signed [aarm_pkg::IN_W-1:0] vz);
      rot_matrix_type res;
      longint r [3];
      longint u [3];
      longint mm [9];
      longint unsigned sum, ang, mag;
      longint th, cx, cy, cz, dx, dy, c, s, t, tx, ty, tz, txy, txz, tyz;
      longint sx, sy, sz, q;
      bit flip;
      r[0] = vx; r[1] = vy; r[2] = vz;
      sum = 0;
      for (int i = 0; i < 3; i++) sum += longint'(r[i] * r[i]);
      if (sum == 0) begin
         for (int i = 0; i < 9; i++)
            res.m[i] = round_sat((i % 4 == 0) ? (longint'(1) << aarm_pkg::Q) : 0);
         res.ident = 1'b1;
         return res;
      end
      ang = int_sqrt(sum << 32);
      for (int i = 0; i < 3; i++) begin
         mag = (r[i] < 0) ? -r[i] : r[i];
         q = longint'((mag << 46) / ang);
         u[i] = (r[i] < 0) ? -q : q;
      end
      // reduce angle into [-pi/2, pi/2]
      th = longint'(ang << 1);
      flip = 0;
      if (th > longint'(aarm_pkg::PI_Q)) th -= longint'(aarm_pkg::TWO_PI_Q);
      if (th > longint'(aarm_pkg::HALF_PI_Q)) begin
         th -= longint'(aarm_pkg::PI_Q); flip = 1;
      end else if (th < -longint'(aarm_pkg::HALF_PI_Q)) begin
         th += longint'(aarm_pkg::PI_Q); flip = 1;
      end
      // cordic rotation
      cx = longint'(aarm_pkg::GAIN_Q); cy = 0; cz = th;
      for (int i = 0; i < aarm_pkg::CORDIC_STAGES && i < aarm_pkg::ATAN_COUNT; i++) begin
         dx = floor_shr(cy, i); dy = floor_shr(cx, i);
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= longint'(aarm_pkg::ATAN_Q[i]);
         end else begin
            cx += dx; cy -= dy; cz += longint'(aarm_pkg::ATAN_Q[i]);
         end
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
      t = (longint'(1) << aarm_pkg::Q) - c;
      tx = qmul(t, u[0]); ty = qmul(t, u[1]); tz = qmul(t, u[2]);
      txy = qmul(tx, u[1]); txz = qmul(tx, u[2]); tyz = qmul(ty, u[2]);
      sx = qmul(s, u[0]); sy = qmul(s, u[1]); sz = qmul(s, u[2]);
      mm[0] = qmul(tx, u[0]) + c; mm[1] = txy - sz; mm[2] = txz + sy;
      mm[3] = txy + sz; mm[4] = qmul(ty, u[1]) + c; mm[5] = tyz - sx;
      mm[6] = txz - sy; mm[7] = tyz + sx; mm[8] = qmul(tz, u[2]) + c;
      for (int i = 0; i < 9; i++) res.m[i] = round_sat(mm[i]);
      res.ident = 1'b0;
      return res;
   endfunction

   // predict on accepted request beats, compare on response strobes
   always @(posedge clock) begin
      rot_matrix_type want;
      logic [aarm_pkg::OUT_W-1:0] got [9];
      bit bad;
      if (reset) begin
         fail_count <= 0; matrices_seen <= 0; identities_seen <= 0;
      end else begin
         if (start && !busy)
            matrix_queue = {matrix_queue, rodrigues(req_rot_x, req_rot_y, req_rot_z)};
         if (rsp_valid) begin
            got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                    rsp_m20, rsp_m21, rsp_m22};
            matrices_seen <= matrices_seen + 1;
            if (matrix_queue.size() == 0) begin
               $display("%0t: unexpected result beat", $time);
               fail_count <= fail_count + 1;
            end else begin
               want = matrix_queue.pop_front();
               if (want.ident) identities_seen <= identities_seen + 1;
               bad = (want.ident != rsp_was_identity);
               for (int i = 0; i < 9; i++)
                  if (want.m[i] != got[i]) bad = 1'b1;
               if (bad) begin
                  fail_count <= fail_count + 1;
                  for (int i = 0; i < 9; i++)
                     if (want.m[i] != got[i])
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                                 $signed(want.m[i]), $signed(got[i]));
                  if (want.ident != rsp_was_identity)
                     $display("%0t: was_identity expected %0d actual %0d", $time,
                              want.ident, rsp_was_identity);
               end
            end
         end
      end
      pending <= matrix_queue.size();
   end

endmodule

/* sim/tb_axis_angle_to_rotation_matrix_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_to_rotation_matrix_unit: stimulus and verdict
// Drives directed and random rotation vectors with random start gaps and
// reports the outcome of the scoreboard in aarm_checker.
// ----------------------------------------------------------------------------
module tb_axis_angle_to_rotation_matrix_unit;

   localparam int RANDOM_BEATS = 600;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 0, reset = 1, start = 0, busy;
   logic signed [aarm_pkg::IN_W-1:0] req_rot_x = 0, req_rot_y = 0, req_rot_z = 0;
   logic rsp_valid, rsp_was_identity;
   logic signed [aarm_pkg::OUT_W-1:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [aarm_pkg::OUT_W-1:0] rsp_m20, rsp_m21, rsp_m22;
   int fail_count, pending, matrices_seen, identities_seen, cycles = 0;

   always #4 clock = ~clock;

   axis_angle_to_rotation_matrix_unit dut (.*);

   aarm_checker checker_i (.*);

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** axis_angle_to_rotation_matrix_unit: FAILED **");
         $finish;
      end
   end

   // hold one beat on the request port until accepted
   task automatic send_vector(logic [aarm_pkg::IN_W-1:0] x, logic [aarm_pkg::IN_W-1:0] y,
                              logic [aarm_pkg::IN_W-1:0] z, bit gaps);
      if (gaps)
         while ($urandom_range(99) < 30) begin
            start <= 0;
            @(posedge clock);
         end
      start <= 1; req_rot_x <= x; req_rot_y <= y; req_rot_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [aarm_pkg::IN_W-1:0] pick_component();
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 200)) - 16'd100;
         2: return 16'($signed(14'($urandom)));
         3: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         default: return 16'($signed($urandom_range(0, 51472)) - 25736);
      endcase
   endfunction

   logic [aarm_pkg::IN_W-1:0] edge_vals [8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                                                16'h8000, 16'd12868, -16'd12868, 16'd25736};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero vector, smallest steps, extremes, angles past pi/2 and pi
      send_vector('0, '0, '0, 1'b0);
      for (int i = 1; i < 8; i++) begin
         send_vector(edge_vals[i], '0, '0, 1'b0);
         send_vector('0, edge_vals[i], '0, 1'b0);
         send_vector('0, '0, edge_vals[i], 1'b0);
      end
      send_vector(16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      send_vector('0, '0, '0, 1'b0);
      // random: first a burst with no gaps, then gaps
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(49) == 0) send_vector('0, '0, '0, n >= 150);
         else send_vector(pick_component(), pick_component(), pick_component(), n >= 150);
      end
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (aarm_pkg::LATENCY + 10) @(posedge clock);
      $display("covered %0d matrices, %0d of them identity, zero to full-scale vectors",
               matrices_seen, identities_seen);
      if (fail_count == 0 && pending == 0)
         $display("** axis_angle_to_rotation_matrix_unit: PASSED **");
      else
         $display("** axis_angle_to_rotation_matrix_unit: FAILED **");
      $finish;
   end

endmodule
